FILE: rtl/mcds_pkg.sv
package mcds_pkg;

    localparam logic [11:0] FIRST_YEAR    = 12'd1900;
    // Leap years counted in 1..1899.
    localparam logic [12:0] LEAPS_BEFORE  = 13'd460;
    // floor(x / 100) = (x * RECIP_100) >> SHIFT_100 for any 12-bit x.
    localparam logic [24:0] RECIP_100     = 25'd5243;
    localparam int          SHIFT_100     = 19;
    // floor(x / 7) = (x * RECIP_7) >> SHIFT_7 for any 13-bit x.
    localparam logic [26:0] RECIP_7       = 27'd9363;
    localparam int          SHIFT_7       = 16;
    localparam logic [2:0]  LAST_WEEKDAY  = 3'd6;

    typedef enum logic [2:0] {
        S_IDLE,
        S_CALC_Q,
        S_CALC_SUM,
        S_CALC_DIV,
        S_CALC_WD,
        S_EMIT
    } t_state;

    typedef struct packed {
        logic load;
        logic calc_q;
        logic calc_sum;
        logic calc_div;
        logic calc_wd;
        logic advance;
    } t_cmd;

    typedef struct packed {
        logic bad;
        logic last;
    } t_stat;

    // Days in a common year before the 1st of month m.
    function automatic logic [8:0] days_before(input logic [3:0] m);
        logic [8:0] d;
        case (m)
            4'd1:    d = 9'd0;
            4'd2:    d = 9'd31;
            4'd3:    d = 9'd59;
            4'd4:    d = 9'd90;
            4'd5:    d = 9'd120;
            4'd6:    d = 9'd151;
            4'd7:    d = 9'd181;
            4'd8:    d = 9'd212;
            4'd9:    d = 9'd243;
            4'd10:   d = 9'd273;
            4'd11:   d = 9'd304;
            4'd12:   d = 9'd334;
            default: d = 9'd0;
        endcase
        return d;
    endfunction

    // Length of month m in a common year.
    function automatic logic [4:0] month_len(input logic [3:0] m);
        logic [4:0] l;
        case (m)
            4'd2:                      l = 5'd28;
            4'd4, 4'd6, 4'd9, 4'd11:   l = 5'd30;
            default:                   l = 5'd31;
        endcase
        return l;
    endfunction

endpackage

FILE: rtl/mcds_ctrl.sv
module mcds_ctrl
    import mcds_pkg::*;
(
    input  logic  i_clk,
    input  logic  i_rst_n,
    input  logic  i_in_valid,
    output logic  o_in_ready,
    output logic  o_out_valid,
    input  logic  i_out_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state     = r_state;
        o_cmd       = '0;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_state    = i_stat.bad ? S_EMIT : S_CALC_Q;
                end
            end
            S_CALC_Q: begin
                o_cmd.calc_q = 1'b1;
                n_state      = S_CALC_SUM;
            end
            S_CALC_SUM: begin
                o_cmd.calc_sum = 1'b1;
                n_state        = S_CALC_DIV;
            end
            S_CALC_DIV: begin
                o_cmd.calc_div = 1'b1;
                n_state        = S_CALC_WD;
            end
            S_CALC_WD: begin
                o_cmd.calc_wd = 1'b1;
                n_state       = S_EMIT;
            end
            S_EMIT: begin
                o_out_valid = 1'b1;
                if (i_out_ready) begin
                    if (i_stat.last) begin
                        n_state = S_IDLE;
                    end else begin
                        o_cmd.advance = 1'b1;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: rtl/mcds_dp.sv
module mcds_dp
    import mcds_pkg::*;
(
    input  logic        i_clk,
    input  logic [11:0] i_year,
    input  logic [3:0]  i_month,
    input  t_cmd        i_cmd,
    output t_stat       o_stat,
    output logic [4:0]  o_day_number,
    output logic [2:0]  o_weekday,
    output logic        o_error
);

    logic [11:0] r_year;
    logic [3:0]  r_month;
    logic [5:0]  r_q100;
    logic [12:0] r_sum;
    logic [4:0]  r_len;
    logic [10:0] r_q7;
    logic [4:0]  r_day;
    logic [2:0]  r_wd;
    logic        r_err;

    logic        w_bad;
    logic [24:0] w_p100;
    logic        w_div100;
    logic        w_leap;
    logic [11:0] w_prev;
    logic [5:0]  w_prev_q100;
    logic [12:0] w_sum;
    logic [26:0] w_p7;
    logic [12:0] w_sub7;

    assign w_bad = (i_year < FIRST_YEAR) || !(i_month inside {[4'd1:4'd12]});

    // Quotient of year by 100, by reciprocal multiply.
    assign w_p100 = 25'(r_year) * RECIP_100;

    assign w_div100    = (r_year == 12'(13'(r_q100) * 13'd100));
    assign w_leap      = ((r_year[1:0] == 2'd0) && !w_div100)
                       || (w_div100 && (r_q100[1:0] == 2'd0));
    assign w_prev      = r_year - 12'd1;
    assign w_prev_q100 = w_div100 ? (r_q100 - 6'd1) : r_q100;

    // Days since 1900-01-01 reduced mod 7 where it is free (365 = 1 mod 7),
    // plus one for the Monday start.
    assign w_sum = 13'(r_year - FIRST_YEAR)
                 + 13'(w_prev[11:2])
                 - 13'(w_prev_q100)
                 + 13'(w_prev_q100[5:2])
                 - LEAPS_BEFORE
                 + 13'(days_before(r_month))
                 + 13'((r_month > 4'd2) && w_leap)
                 + 13'd1;

    assign w_p7   = 27'(r_sum) * RECIP_7;
    assign w_sub7 = 13'(14'(r_q7) * 14'd7);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_year  <= i_year;
            r_month <= i_month;
            r_day   <= 5'd0;
            r_wd    <= 3'd0;
            r_err   <= w_bad;
        end
        if (i_cmd.calc_q) begin
            r_q100 <= w_p100[SHIFT_100 +: 6];
        end
        if (i_cmd.calc_sum) begin
            r_sum <= w_sum;
            r_len <= ((r_month == 4'd2) && w_leap) ? 5'd29 : month_len(r_month);
        end
        if (i_cmd.calc_div) begin
            r_q7 <= w_p7[SHIFT_7 +: 11];
        end
        if (i_cmd.calc_wd) begin
            r_wd  <= 3'(r_sum - w_sub7);
            r_day <= 5'd1;
        end
        if (i_cmd.advance) begin
            r_day <= r_day + 5'd1;
            r_wd  <= (r_wd == LAST_WEEKDAY) ? 3'd0 : (r_wd + 3'd1);
        end
    end

    assign o_stat.bad    = w_bad;
    assign o_stat.last   = r_err || (r_day == r_len);
    assign o_day_number  = r_day;
    assign o_weekday     = r_wd;
    assign o_error       = r_err;

endmodule

FILE: rtl/month_calendar_day_stream.sv
// Channel   Dir  tdata                              tuser   tlast
// s_axis    in   [11:0] year, [15:12] month         -       -
// m_axis    out  [4:0] day_number, [7:5] weekday    error   is_last
//
// One item at a time: a valid year/month is accepted, runs the setup steps
// (quotient by 100, day sum, quotient by 7, weekday) in order and then makes
// one transfer per day, 28 to 31 of them. A rejected item is accepted and
// makes one error transfer.
// Setup runs through the two separate reciprocal multipliers of the datapath.
// Reset (i_rst_n low, synchronous) returns the controller to idle; the
// datapath registers hold payload only. An output stall holds the current
// transfer and pauses the day count.
module month_calendar_day_stream
    import mcds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_axis_tvalid,
    output logic        o_s_axis_tready,
    input  logic [15:0] i_s_axis_tdata,   // [11:0] year, [15:12] month
    output logic        o_m_axis_tvalid,
    input  logic        i_m_axis_tready,
    output logic [7:0]  o_m_axis_tdata,   // [4:0] day_number, [7:5] weekday
    output logic        o_m_axis_tuser,   // [0] error
    output logic        o_m_axis_tlast    // is_last
);

    t_cmd       w_cmd;
    t_stat      w_stat;
    logic [4:0] w_day;
    logic [2:0] w_wd;
    logic       w_err;

    // Sequence the setup steps and the per-day transfers.
    mcds_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_s_axis_tvalid),
        .o_in_ready  (o_s_axis_tready),
        .o_out_valid (o_m_axis_tvalid),
        .i_out_ready (i_m_axis_tready),
        .i_stat      (w_stat),
        .o_cmd       (w_cmd)
    );

    // Hold the item, compute the first weekday, step through the days.
    mcds_dp u_dp (
        .i_clk        (i_clk),
        .i_year       (i_s_axis_tdata[11:0]),
        .i_month      (i_s_axis_tdata[15:12]),
        .i_cmd        (w_cmd),
        .o_stat       (w_stat),
        .o_day_number (w_day),
        .o_weekday    (w_wd),
        .o_error      (w_err)
    );

    assign o_m_axis_tdata = {w_wd, w_day};
    assign o_m_axis_tuser = w_err;
    assign o_m_axis_tlast = w_stat.last;

endmodule

FILE: rtl/mcds_checker.sv
module mcds_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        o_s_axis_tready,
    input logic        o_m_axis_tvalid,
    input logic        i_m_axis_tready,
    input logic [7:0]  o_m_axis_tdata,
    input logic        o_m_axis_tuser,
    input logic        o_m_axis_tlast
);

    // A stalled transfer holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=>
            o_m_axis_tvalid && $stable(o_m_axis_tdata) && $stable(o_m_axis_tlast))
        else $error("output changed while stalled");

    // An error result is a single all-zero last transfer.
    a_err: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && o_m_axis_tuser |-> o_m_axis_tlast && o_m_axis_tdata == 8'd0)
        else $error("malformed error result");

    // Days advance by one and weekdays wrap Saturday to Sunday.
    a_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && i_m_axis_tready && !o_m_axis_tlast |=>
            o_m_axis_tvalid
            && o_m_axis_tdata[4:0] == $past(o_m_axis_tdata[4:0]) + 5'd1
            && ((o_m_axis_tdata[7:5] == $past(o_m_axis_tdata[7:5]) + 3'd1)
                || (o_m_axis_tdata[7:5] == 3'd0 && $past(o_m_axis_tdata[7:5]) == 3'd6)))
        else $error("day sequence broken");

    // No new item is taken while a month's transfers are offered.
    a_one: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid |-> !o_s_axis_tready)
        else $error("input accepted during output");

endmodule

bind month_calendar_day_stream mcds_checker u_mcds_checker (.*);

FILE: tb/calendar_day_checker.sv
module calendar_day_checker
    import mcds_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,    // [11:0] year, [15:12] month
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [7:0]  i_m_tdata,    // [4:0] day_number, [7:5] weekday
    input  logic        i_m_tuser,    // [0] error
    input  logic        i_m_tlast,    // is_last
    output int          o_failures,
    output int          o_pending
);

    localparam int unsigned EPOCH_WEEKDAY = 1;   // 1 Jan 1900 was a Monday
    localparam int unsigned DAYS_PER_WEEK = 7;
    localparam logic [3:0]  JANUARY       = 4'd1;
    localparam logic [3:0]  FEBRUARY      = 4'd2;
    localparam logic [3:0]  APRIL         = 4'd4;
    localparam logic [3:0]  JUNE          = 4'd6;
    localparam logic [3:0]  SEPTEMBER     = 4'd9;
    localparam logic [3:0]  NOVEMBER      = 4'd11;
    localparam logic [3:0]  DECEMBER      = 4'd12;

    typedef struct {
        logic [4:0] day_number;
        logic [2:0] weekday;
        logic       is_last;
        logic       error;
    } t_day_entry;

    t_day_entry expected_days[$];
    int         mismatch_count = 0;
    int         pending_count  = 0;

    assign o_failures = mismatch_count;
    assign o_pending  = pending_count;

    function automatic bit gregorian_leap(input int unsigned year);
        return ((year % 4 == 0) && (year % 100 != 0)) || (year % 400 == 0);
    endfunction

    function automatic int unsigned days_in_month(input int unsigned year,
                                                  input logic [3:0] month);
        if (month == FEBRUARY)
            return gregorian_leap(year) ? 29 : 28;
        if (month == APRIL || month == JUNE || month == SEPTEMBER || month == NOVEMBER)
            return 30;
        return 31;
    endfunction

    // Queue every day of the month, or a single error entry for a bad date.
    task automatic queue_month_days(input logic [11:0] year, input logic [3:0] month);
        int unsigned elapsed;
        int unsigned first_wd;
        int unsigned len;
        t_day_entry  entry;
        elapsed = 0;
        if (year < FIRST_YEAR || month < JANUARY || month > DECEMBER) begin
            entry.day_number = '0;
            entry.weekday    = '0;
            entry.is_last    = 1'b1;
            entry.error      = 1'b1;
            expected_days.push_back(entry);
        end else begin
            // Walk whole years, then whole months, from the epoch.
            for (int unsigned y = FIRST_YEAR; y < year; y++)
                elapsed += gregorian_leap(y) ? 366 : 365;
            for (logic [3:0] m = JANUARY; m < month; m++)
                elapsed += days_in_month(year, m);
            first_wd = (elapsed + EPOCH_WEEKDAY) % DAYS_PER_WEEK;
            len      = days_in_month(year, month);
            for (int unsigned d = 0; d < len; d++) begin
                entry.day_number = 5'(d + 1);
                entry.weekday    = 3'((first_wd + d) % DAYS_PER_WEEK);
                entry.is_last    = (d + 1 == len);
                entry.error      = 1'b0;
                expected_days.push_back(entry);
            end
        end
    endtask

    always @(posedge i_clk) begin
        t_day_entry want;
        if (i_rst_n) begin
            if (i_m_tvalid && i_m_tready) begin
                if (expected_days.size() == 0) begin
                    $error("unexpected day transfer: tdata %h tuser %b tlast %b",
                           i_m_tdata, i_m_tuser, i_m_tlast);
                    mismatch_count++;
                end else begin
                    want = expected_days.pop_front();
                    if (i_m_tdata[4:0] !== want.day_number) begin
                        $error("day_number: expected %0d, got %0d",
                               want.day_number, i_m_tdata[4:0]);
                        mismatch_count++;
                    end
                    if (i_m_tdata[7:5] !== want.weekday) begin
                        $error("weekday: expected %0d, got %0d",
                               want.weekday, i_m_tdata[7:5]);
                        mismatch_count++;
                    end
                    if (i_m_tlast !== want.is_last) begin
                        $error("is_last: expected %0d, got %0d", want.is_last, i_m_tlast);
                        mismatch_count++;
                    end
                    if (i_m_tuser !== want.error) begin
                        $error("error: expected %0d, got %0d", want.error, i_m_tuser);
                        mismatch_count++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready)
                queue_month_days(i_s_tdata[11:0], i_s_tdata[15:12]);
            pending_count = expected_days.size();
        end
    end

endmodule

FILE: tb/tb_top.sv
module tb_top
    import mcds_pkg::*;
();

    // Hold the receiver off this long once, so the block backs up into its input.
    localparam int SINK_HOLD_CYCLES = 400;
    // Cycles without any transfer before the run is declared hung.
    localparam int STALL_LIMIT      = 3000;
    // Extra cycles after the last expected day, to catch stray transfers.
    localparam int DRAIN_CYCLES     = 50;
    localparam int ITEMS_PER_PHASE  = 38;
    localparam logic [3:0] JANUARY  = 4'd1;
    localparam logic [3:0] FEBRUARY = 4'd2;
    localparam logic [3:0] DECEMBER = 4'd12;
    localparam logic [3:0] MONTH_13 = 4'd13;
    localparam logic [3:0] MONTH_15 = 4'd15;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;    // [11:0] year, [15:12] month
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [7:0]  m_tdata;          // [4:0] day_number, [7:5] weekday
    logic        m_tuser;          // [0] error
    logic        m_tlast;          // is_last

    int failures;
    int pending;
    int sender_idle_pct = 0;
    int sink_stall_pct  = 0;
    bit sink_hold_req   = 1'b0;
    bit s_accepted      = 1'b0;
    int quiet_cycles    = 0;

    always #5 clk = ~clk;

    month_calendar_day_stream uut (
        .i_clk           (clk),
        .i_rst_n         (rst_n),
        .i_s_axis_tvalid (s_tvalid),
        .o_s_axis_tready (s_tready),
        .i_s_axis_tdata  (s_tdata),
        .o_m_axis_tvalid (m_tvalid),
        .i_m_axis_tready (m_tready),
        .o_m_axis_tdata  (m_tdata),
        .o_m_axis_tuser  (m_tuser),
        .o_m_axis_tlast  (m_tlast)
    );

    calendar_day_checker day_checker (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_s_tvalid (s_tvalid),
        .i_s_tready (s_tready),
        .i_s_tdata  (s_tdata),
        .i_m_tvalid (m_tvalid),
        .i_m_tready (m_tready),
        .i_m_tdata  (m_tdata),
        .i_m_tuser  (m_tuser),
        .i_m_tlast  (m_tlast),
        .o_failures (failures),
        .o_pending  (pending)
    );

    // Record each input transfer at the edge so the sender can see it at the
    // following falling edge without racing the block.
    always @(posedge clk)
        s_accepted <= s_tvalid && s_tready;

    // Watchdog: count edges with no transfer on either channel.
    always @(posedge clk) begin
        if (!rst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Simulation FAILED");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // Receiver: stall at random, or hold off for a long stretch when asked.
    initial begin
        forever begin
            @(negedge clk);
            if (sink_hold_req) begin
                sink_hold_req = 1'b0;
                m_tready <= 1'b0;
                repeat (SINK_HOLD_CYCLES) @(negedge clk);
            end else begin
                m_tready <= ($urandom_range(99) >= sink_stall_pct);
            end
        end
    end

    // Offer one year/month and wait for its transfer. Called at a falling edge;
    // returns at the falling edge right after the transfer.
    task automatic offer_month(input logic [11:0] year, input logic [3:0] month);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {month, year};
        do @(negedge clk); while (!s_accepted);
    endtask

    // Mostly real dates with random content; the rest are rejected dates.
    task automatic offer_random_month();
        int          pick;
        logic [11:0] year;
        logic [3:0]  month;
        pick = $urandom_range(99);
        if (pick < 8) begin
            year  = 12'($urandom_range(1899, 0));
            month = 4'($urandom_range(15, 0));
        end else if (pick < 16) begin
            year  = 12'($urandom_range(4095, FIRST_YEAR));
            month = $urandom_range(1) ? 4'd0 : 4'($urandom_range(MONTH_15, MONTH_13));
        end else if (pick < 30) begin
            // February around century and leap boundaries
            year  = 12'($urandom_range(40, 19) * 100 + $urandom_range(8, 0) - 4);
            if (year < FIRST_YEAR)
                year = FIRST_YEAR;
            month = FEBRUARY;
        end else begin
            year  = 12'($urandom_range(4095, FIRST_YEAR));
            month = 4'($urandom_range(DECEMBER, JANUARY));
        end
        offer_month(year, month);
    endtask

    initial begin
        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Directed: range edges, rejected dates, leap rules, every month.
        offer_month(FIRST_YEAR, JANUARY);
        offer_month(12'd4095, DECEMBER);
        offer_month(12'd1899, JANUARY);
        offer_month(12'd0, 4'd0);
        offer_month(12'd4095, MONTH_15);
        offer_month(FIRST_YEAR, 4'd0);
        offer_month(12'd2000, MONTH_13);
        offer_month(12'd4095, 4'd0);
        offer_month(FIRST_YEAR, FEBRUARY);
        offer_month(12'd2000, FEBRUARY);
        offer_month(12'd2100, FEBRUARY);
        offer_month(12'd2023, FEBRUARY);
        for (int m = 1; m <= 12; m++)
            offer_month(12'd2024, 4'(m));

        // Random, no idling; starve the output first so the input backs up.
        sink_hold_req = 1'b1;
        for (int n = 0; n < ITEMS_PER_PHASE; n++)
            offer_random_month();

        sender_idle_pct = 45;
        sink_stall_pct  = 0;
        for (int n = 0; n < ITEMS_PER_PHASE; n++)
            offer_random_month();

        sender_idle_pct = 0;
        sink_stall_pct  = 45;
        for (int n = 0; n < ITEMS_PER_PHASE; n++)
            offer_random_month();

        sender_idle_pct = 30;
        sink_stall_pct  = 30;
        for (int n = 0; n < ITEMS_PER_PHASE; n++)
            offer_random_month();

        s_tvalid <= 1'b0;

        // Drain; the watchdog catches any day that never arrives.
        while (pending != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);

        if (failures == 0 && pending == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

FILE: sim.f
rtl/mcds_pkg.sv
rtl/mcds_ctrl.sv
rtl/mcds_dp.sv
rtl/month_calendar_day_stream.sv
rtl/mcds_checker.sv
tb/calendar_day_checker.sv
tb/tb_top.sv
